@@ rtl/lxd_pkg.sv @@
// shared types and constants for the length/xor packet deframer
package lxd_pkg;

    localparam int unsigned MAX_BYTES_DEF = 64;

    localparam logic [7:0] START_MARKER_RST   = 8'hA0;
    localparam logic [7:0] STATUS_COMMAND_RST = 8'h10;
    localparam logic [7:0] ZONES_COMMAND_RST  = 8'h20;
    localparam logic [7:0] INSERT_COMMAND_RST = 8'h30;

    // byte positions inside a packet, start marker is position 1
    localparam int unsigned LEN_POS     = 2;
    localparam int unsigned CMD_POS     = 3;
    localparam int unsigned PAYLOAD_POS = 4;
    localparam int unsigned MIN_PKT_LEN = 4;

    typedef enum logic [1:0] {
        CFG_START_MARKER,
        CFG_STATUS_COMMAND,
        CFG_ZONES_COMMAND,
        CFG_INSERT_COMMAND
    } cfg_idx_t;

    typedef enum logic [2:0] {
        EV_NONE,
        EV_STATUS,
        EV_ZONES,
        EV_INSERT,
        EV_UNKNOWN,
        EV_SHORT,
        EV_CHECKSUM,
        EV_OVERFLOW
    } event_t;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] status_command;
        logic [7:0] zones_command;
        logic [7:0] insert_command;
    } cfg_t;

    typedef struct packed {
        logic [7:0] rx_byte;
    } rx_item_t;

    typedef struct packed {
        event_t     event_code;
        logic [7:0] status_value;
        logic [7:0] zones_value;
        logic [7:0] insert_value;
    } ev_item_t;

endpackage

@@ rtl/lxd_stream_if.sv @@
// valid/ready stream channel carrying one payload beat
interface lxd_stream_if #(
    parameter type payload_t = logic [7:0]
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/lxd_parser.sv @@
// packet state tracking, xor check and command decode for one byte
module lxd_parser #(
    parameter int unsigned MAX_BYTES = lxd_pkg::MAX_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    input  lxd_pkg::cfg_t     cfg,
    output lxd_pkg::ev_item_t result
);
    import lxd_pkg::*;

    localparam int unsigned CntW = $clog2(MAX_BYTES);

    logic            in_packet_reg, in_packet_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [7:0]      length_reg, length_next;
    logic [7:0]      command_reg, command_next;
    logic [7:0]      payload_reg, payload_next;
    logic [7:0]      xor_reg, xor_next;
    logic [7:0]      status_reg, status_next;
    logic [7:0]      zones_reg, zones_next;
    logic [7:0]      insert_reg, insert_next;
    logic [CntW:0]   cnt_inc;
    event_t          event_code;

    assign cnt_inc = {1'b0, count_reg} + (CntW+1)'(1);

    always_comb
    begin
        in_packet_next = in_packet_reg;
        count_next     = count_reg;
        length_next    = length_reg;
        command_next   = command_reg;
        payload_next   = payload_reg;
        xor_next       = xor_reg;
        status_next    = status_reg;
        zones_next     = zones_reg;
        insert_next    = insert_reg;
        event_code     = EV_NONE;

        if (!in_packet_reg)
        begin
            if (rx_byte == cfg.start_marker)
            begin
                in_packet_next = 1'b1;
                count_next     = CntW'(1);
                xor_next       = rx_byte;
            end
        end
        else
        begin
            xor_next = xor_reg ^ rx_byte;
            if (cnt_inc == (CntW+1)'(LEN_POS))
                length_next = rx_byte;
            else if (cnt_inc == (CntW+1)'(CMD_POS))
                command_next = rx_byte;
            else if (cnt_inc == (CntW+1)'(PAYLOAD_POS))
                payload_next = rx_byte;

            // overflow wins over completion
            priority if (cnt_inc >= (CntW+1)'(MAX_BYTES))
            begin
                event_code     = EV_OVERFLOW;
                in_packet_next = 1'b0;
                count_next     = '0;
            end
            else if (cnt_inc > (CntW+1)'(LEN_POS) && 8'(cnt_inc) == length_reg)
            begin
                in_packet_next = 1'b0;
                count_next     = '0;
                priority if (cnt_inc < (CntW+1)'(MIN_PKT_LEN))
                    event_code = EV_SHORT;
                else if (xor_next != 8'h00)
                    event_code = EV_CHECKSUM;
                else if (command_next == cfg.status_command)
                begin
                    event_code  = EV_STATUS;
                    status_next = payload_next;
                end
                else if (command_next == cfg.zones_command)
                begin
                    event_code = EV_ZONES;
                    zones_next = payload_next;
                end
                else if (command_next == cfg.insert_command)
                begin
                    event_code  = EV_INSERT;
                    insert_next = payload_next;
                end
                else
                    event_code = EV_UNKNOWN;
            end
            else
                count_next = cnt_inc[CntW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_packet_reg <= 1'b0;
            count_reg     <= '0;
            length_reg    <= '0;
            command_reg   <= '0;
            payload_reg   <= '0;
            xor_reg       <= '0;
            status_reg    <= '0;
            zones_reg     <= '0;
            insert_reg    <= '0;
        end
        else if (accept)
        begin
            in_packet_reg <= in_packet_next;
            count_reg     <= count_next;
            length_reg    <= length_next;
            command_reg   <= command_next;
            payload_reg   <= payload_next;
            xor_reg       <= xor_next;
            status_reg    <= status_next;
            zones_reg     <= zones_next;
            insert_reg    <= insert_next;
        end
    end

    assign result.event_code   = event_code;
    assign result.status_value = status_next;
    assign result.zones_value  = zones_next;
    assign result.insert_value = insert_next;

endmodule

@@ rtl/length_xor_packet_deframer.sv @@
// top level: start-marker / length / xor checksum packet deframer
// each accepted byte beat gives a result beat, registered and valid in the cycle after the accept
// throughput: one byte per cycle unless a result beat stalls; state updates once per byte
// the output register frees when its beat is taken, so a new byte is taken in that same cycle
// reset: command registers return to defaults, packet state and status registers clear,
// no result beat is pending
module length_xor_packet_deframer #(
    parameter int unsigned MAX_BYTES = lxd_pkg::MAX_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    lxd_stream_if.sink        rx,
    lxd_stream_if.source      ev,
    input  logic              cfg_we,
    input  lxd_pkg::cfg_idx_t cfg_index,
    input  logic [7:0]        cfg_data
);
    import lxd_pkg::*;

    cfg_t     cfg_reg;
    logic     out_valid_reg, out_valid_next;
    ev_item_t out_data_reg;
    ev_item_t result;
    logic     accept;
    rx_item_t rx_item;

    assign rx_item  = rx.data;
    assign rx.ready = !out_valid_reg || ev.ready;
    assign accept   = rx.valid && rx.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_marker   <= START_MARKER_RST;
            cfg_reg.status_command <= STATUS_COMMAND_RST;
            cfg_reg.zones_command  <= ZONES_COMMAND_RST;
            cfg_reg.insert_command <= INSERT_COMMAND_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_MARKER:   cfg_reg.start_marker   <= cfg_data;
                CFG_STATUS_COMMAND: cfg_reg.status_command <= cfg_data;
                CFG_ZONES_COMMAND:  cfg_reg.zones_command  <= cfg_data;
                CFG_INSERT_COMMAND: cfg_reg.insert_command <= cfg_data;
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    lxd_parser #(
        .MAX_BYTES (MAX_BYTES)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_item.rx_byte),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // result beat register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (ev.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= result;
    end

    assign ev.valid = out_valid_reg;
    assign ev.data  = out_data_reg;

endmodule
